// ===== sv/rmsedf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsedf_pkg
// Shared types and constants of the RMS / EDF tick scheduler.
// ----------------------------------------------------------------------------
package rmsedf_pkg;

  localparam int NUM_TASKS_DEF = 8;
  localparam int MAX_TASKS     = 8;
  localparam int TIME_W        = 32;
  localparam int BYTE_W        = 8;
  localparam int TASK_W        = 4;
  localparam int CNT_CFG_W     = 4;
  localparam int WORD_CFG_W    = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_POLICY_MODE = 2'd0;
  localparam cfg_idx_t REG_TASK_COUNT  = 2'd1;
  localparam cfg_idx_t REG_PERIODS     = 2'd2;
  localparam cfg_idx_t REG_EXEC_TIMES  = 2'd3;

  localparam logic                  MODE_RMS     = 1'b0;
  localparam logic                  MODE_EDF     = 1'b1;
  localparam logic [CNT_CFG_W-1:0]  COUNT_RST    = 4'd1;
  localparam logic [WORD_CFG_W-1:0] PERIODS_RST  = 64'h0101_0101_0101_0101;
  localparam logic [WORD_CFG_W-1:0] EXEC_RST     = 64'h0;
  localparam logic [TASK_W-1:0]     TASK_IDLE    = 4'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/rmsedf_if.sv =====
// ----------------------------------------------------------------------------
// rmsedf channel interfaces
// Tick input, schedule result and configuration write channels.
// ----------------------------------------------------------------------------
interface rmsedf_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface rmsedf_out_if;
  import rmsedf_pkg::*;
  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] running_task;
  logic [TIME_W-1:0] tick_time;

  modport source (output valid, output running_task, output tick_time, input ready);
  modport sink   (input valid, input running_task, input tick_time, output ready);
endinterface

interface rmsedf_cfg_if;
  import rmsedf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/rmsedf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmsedf_ctrl
// Sequencer: accept a tick, optional clear, walk the tasks, emit the word.
// ----------------------------------------------------------------------------
module rmsedf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rmsedf_pkg::dp_stat_t stat,
  output rmsedf_pkg::dp_cmd_t  cmd
);
  import rmsedf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/rmsedf_dp.sv =====
// ----------------------------------------------------------------------------
// rmsedf_dp
// Config registers, per-task state, one-task-per-cycle selection, result reg.
// ----------------------------------------------------------------------------
module rmsedf_dp #(
  parameter int NUM_TASKS = rmsedf_pkg::NUM_TASKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_restart,
  input  logic                                cfg_valid,
  input  logic [rmsedf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rmsedf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  rmsedf_pkg::dp_cmd_t                 cmd,
  output rmsedf_pkg::dp_stat_t                stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rmsedf_pkg::TASK_W-1:0]       out_running_task,
  output logic [rmsedf_pkg::TIME_W-1:0]       out_tick_time
);
  import rmsedf_pkg::*;

  localparam int TIDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W  = $clog2(NUM_TASKS + 1);

  // configuration
  logic                  mode_r;
  logic [CNT_CFG_W-1:0]  count_r;
  logic [WORD_CFG_W-1:0] periods_r;
  logic [WORD_CFG_W-1:0] exec_r;

  // per-task state
  logic [BYTE_W-1:0] budget_r   [NUM_TASKS];
  logic [TIME_W-1:0] release_r  [NUM_TASKS];
  logic [TIME_W-1:0] deadline_r [NUM_TASKS];
  logic [TIME_W-1:0] time_r;

  // scan state
  logic              restart_r;
  logic [CNT_W-1:0]  idx_r;
  logic              found_r;
  logic [TIME_W-1:0] best_r;
  logic [TIDX_W-1:0] chosen_r;
  logic [BYTE_W-1:0] chosen_bud_r;

  // result register
  logic              out_valid_r;
  logic [TASK_W-1:0] out_task_r;
  logic [TIME_W-1:0] out_time_r;

  logic [CNT_W-1:0]  n_eff;
  logic [TIDX_W-1:0] ti;
  logic              active;
  logic [BYTE_W-1:0] per;
  logic              hit;
  logic [BYTE_W-1:0] bud_nxt;
  logic [TIME_W-1:0] dl_nxt;
  logic [TIME_W-1:0] rel_nxt;
  logic [TIME_W-1:0] key;
  logic              better;

  always_comb begin
    if (count_r > CNT_CFG_W'(NUM_TASKS)) begin
      n_eff = CNT_W'(NUM_TASKS);
    end else begin
      n_eff = CNT_W'(count_r);
    end
  end

  assign ti      = idx_r[TIDX_W-1:0];
  assign active  = (idx_r < n_eff);
  assign per     = periods_r[BYTE_W*ti +: BYTE_W];
  assign hit     = (release_r[ti] == time_r);
  assign bud_nxt = hit ? exec_r[BYTE_W*ti +: BYTE_W] : budget_r[ti];
  assign dl_nxt  = (hit && mode_r == MODE_EDF) ? time_r + TIME_W'(per) : deadline_r[ti];
  assign rel_nxt = hit ? release_r[ti] + TIME_W'(per) : release_r[ti];
  assign key     = (mode_r == MODE_EDF) ? dl_nxt : TIME_W'(per);
  assign better  = (bud_nxt != '0) && (!found_r || key < best_r);

  assign stat.scan_last = ({1'b0, idx_r} + 1'b1) >= {1'b0, n_eff};
  assign stat.out_free  = !out_valid_r || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RMS;
      count_r   <= COUNT_RST;
      periods_r <= PERIODS_RST;
      exec_r    <= EXEC_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POLICY_MODE: mode_r    <= cfg_data[0];
        REG_TASK_COUNT:  count_r   <= cfg_data[CNT_CFG_W-1:0];
        REG_PERIODS:     periods_r <= cfg_data[WORD_CFG_W-1:0];
        REG_EXEC_TIMES:  exec_r    <= cfg_data[WORD_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // task state and time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        budget_r[i]   <= '0;
        release_r[i]  <= '0;
        deadline_r[i] <= TIME_W'(PERIODS_RST[BYTE_W*i +: BYTE_W]);
      end
    end else begin
      if (cmd.clear && restart_r) begin
        time_r <= '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
          budget_r[i]   <= '0;
          release_r[i]  <= '0;
          deadline_r[i] <= TIME_W'(periods_r[BYTE_W*i +: BYTE_W]);
        end
      end
      if (cmd.step && active) begin
        budget_r[ti]   <= bud_nxt;
        release_r[ti]  <= rel_nxt;
        deadline_r[ti] <= dl_nxt;
      end
      if (cmd.load_out) begin
        time_r <= time_r + 1'b1;
        if (found_r) begin
          budget_r[chosen_r] <= chosen_bud_r - 1'b1;
        end
      end
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r <= 1'b0;
      idx_r     <= '0;
      found_r   <= 1'b0;
    end else if (cmd.start) begin
      restart_r <= in_restart;
      idx_r     <= '0;
      found_r   <= 1'b0;
    end else if (cmd.step) begin
      if (!stat.scan_last) begin
        idx_r <= idx_r + 1'b1;
      end
      if (active && better) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && active && better) begin
      best_r       <= key;
      chosen_r     <= ti;
      chosen_bud_r <= bud_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_task_r <= found_r ? TASK_W'(chosen_r) + 1'b1 : TASK_IDLE;
      out_time_r <= time_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_running_task = out_task_r;
  assign out_tick_time    = out_time_r;

endmodule

// ===== sv/rms_edf_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// rms_edf_tick_scheduler
// Periodic task scheduler, rate monotonic or earliest deadline first,
// advanced one time tick per input word.
//
//   channel  dir  carries
//   in_ch    in   restart
//   out_ch   out  running_task, tick_time
//   cfg_ch   in   index, data (policy_mode, task_count, periods, exec times)
//
// a tick passes from accept to result register through the accept, the clear slot,
// the selection walk over the tasks in use (always at least one step),
// then the commit that loads the result register
// the walk runs a single compare unit over the task entries in turn
// a pending result does not block the next accept; the commit waits for it
// rst_n is synchronous; it loads the register defaults and clears the state
// ----------------------------------------------------------------------------
module rms_edf_tick_scheduler #(
  parameter int NUM_TASKS = rmsedf_pkg::NUM_TASKS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  rmsedf_in_if.sink    in_ch,
  rmsedf_out_if.source out_ch,
  rmsedf_cfg_if.sink   cfg_ch
);
  import rmsedf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  rmsedf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmsedf_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_restart       (in_ch.restart),
    .cfg_valid        (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_running_task (out_ch.running_task),
    .out_tick_time    (out_ch.tick_time)
  );

endmodule

// ===== sv/rmsedf_checker.sv =====
// ----------------------------------------------------------------------------
// rmsedf_checker
// Port-level checks of the tick scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rmsedf_checker #(
  parameter int NUM_TASKS = rmsedf_pkg::NUM_TASKS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rmsedf_pkg::TASK_W-1:0]   out_running_task,
  input logic [rmsedf_pkg::TIME_W-1:0]   out_tick_time
);
  import rmsedf_pkg::*;

  // result word held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_running_task) && $stable(out_tick_time))
    else $error("result word changed while stalled");

  // one tick in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a tick is in progress");

  a_task_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_running_task <= TASK_W'(NUM_TASKS))
    else $error("running task out of range");

endmodule

bind rms_edf_tick_scheduler rmsedf_checker #(
  .NUM_TASKS (NUM_TASKS)
) u_rmsedf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_running_task (out_ch.running_task),
  .out_tick_time    (out_ch.tick_time)
);
